// ----- rtl/rhsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rhsd_pkg
// Shared constants and types of the acoustic volume right-hand-side block.
// ----------------------------------------------------------------------------
package rhsd_pkg;

  localparam int TERMS_PER_NODE = 3;
  localparam int FRAC_BITS      = 16;

  localparam int DATA_W   = 32;            // Q16.16 words
  localparam int DIFF_W   = DATA_W + 1;    // exact neighbor minus base
  localparam int NUM_ACC  = 6;             // du/dr du/ds dv/dr dv/ds dp/dr dp/ds
  localparam int ACC_W    = 48;
  localparam int IN_W     = 10 * DATA_W;   // weight and nine field values
  localparam int OUT_W    = 3 * DATA_W;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_GEO_R_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GEO_R_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GEO_S_X = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GEO_S_Y = 2'd3;

  // One classified term as it waits for the datapath.
  typedef struct packed {
    logic signed [DATA_W-1:0]       weight;
    logic [NUM_ACC-1:0][DIFF_W-1:0] diff;    // index = accumulator index
    logic                           done;    // node ends with this term
  } term_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [DATA_W-1:0] s_x;
    logic signed [DATA_W-1:0] s_y;
  } geo_t;

endpackage

// ----- rtl/acoustic_volume_rhs_sparse_diff_top.sv -----
// ----------------------------------------------------------------------------
// acoustic_volume_rhs_sparse_diff_top
// Acoustic volume right-hand side of one triangle node from a sparse
// three-term derivative, emitting -dp/dx, -dp/dy and -(du/dx + dv/dy).
// ----------------------------------------------------------------------------
// Each input beat is one derivative term; a node ends on tlast or on its
// third term, and then one result beat follows. Terms enter a two-entry
// queue and are worked off by a single shared 33x33 multiplier: a term takes
// six multiply-accumulates and one dispatch state, and a node's last term
// adds the sixteen half-word chain-rule products, the pipeline drain and
// the output load. The geometric factors are read at the node end, so
// write them between nodes while the block is idle.
module acoustic_volume_rhs_sparse_diff_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // term_weight, u_base, u_rnb, u_snb, v_base, v_rnb, v_snb,
  // p_base, p_rnb, p_snb (32 bits each)
  input  logic [rhsd_pkg::IN_W-1:0]         s_axis_tdata,
  input  logic                              s_axis_tlast,     // last_term
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // rhs_u, rhs_v, rhs_p (32 bits each)
  output logic [rhsd_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [rhsd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rhsd_pkg::DATA_W-1:0]       cfg_wdata
);

  rhsd_pkg::geo_t  geo;
  rhsd_pkg::term_t front_data;
  rhsd_pkg::term_t q_data;
  logic            q_ready;
  logic            q_push;
  logic            q_valid;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      geo <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rhsd_pkg::REG_GEO_R_X: geo.r_x <= $signed(cfg_wdata);
        rhsd_pkg::REG_GEO_R_Y: geo.r_y <= $signed(cfg_wdata);
        rhsd_pkg::REG_GEO_S_X: geo.s_x <= $signed(cfg_wdata);
        rhsd_pkg::REG_GEO_S_Y: geo.s_y <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  rhsd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_data        (front_data)
  );

  rhsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_data),
    .in_ready  (q_ready),
    .pop       (q_pop),
    .out_valid (q_valid),
    .out_data  (q_data)
  );

  rhsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .geo           (geo),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- rtl/rhsd_queue.sv -----
// ----------------------------------------------------------------------------
// rhsd_queue
// Short FIFO of classified terms between the front end and the datapath.
// ----------------------------------------------------------------------------
module rhsd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rhsd_pkg::term_t push_data,
  output logic            in_ready,
  input  logic            pop,
  output logic            out_valid,
  output rhsd_pkg::term_t out_data
);

  localparam int DEPTH = rhsd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rhsd_pkg::term_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CNT_W'(DEPTH)) || pop)
    else $error("queue pushed while full");
`endif

endmodule

// ----- rtl/rhsd_front.sv -----
// ----------------------------------------------------------------------------
// rhsd_front
// Input side: take a term beat, form the six exact differences and mark
// whether the node ends with it.
// ----------------------------------------------------------------------------
module rhsd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [rhsd_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                        s_axis_tlast,
  input  logic                        q_ready,
  output logic                        q_push,
  output rhsd_pkg::term_t             q_data
);

  localparam int W     = rhsd_pkg::DATA_W;
  localparam int DW    = rhsd_pkg::DIFF_W;
  localparam int TPN   = rhsd_pkg::TERMS_PER_NODE;
  localparam int CNT_W = (TPN > 1) ? $clog2(TPN) : 1;

  logic [CNT_W-1:0] term_cnt;
  logic             done;

  assign s_axis_tready = q_ready;
  assign q_push        = s_axis_tvalid && q_ready;

  assign done = s_axis_tlast ||
                ((CNT_W + 1)'(term_cnt) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(TPN));

  always_comb begin
    logic signed [DW-1:0] base;
    logic signed [DW-1:0] rnb;
    logic signed [DW-1:0] snb;
    q_data.weight = $signed(s_axis_tdata[W-1:0]);
    q_data.done   = done;
    for (int f = 0; f < 3; f++) begin
      base = DW'($signed(s_axis_tdata[(3*f+1)*W +: W]));
      rnb  = DW'($signed(s_axis_tdata[(3*f+2)*W +: W]));
      snb  = DW'($signed(s_axis_tdata[(3*f+3)*W +: W]));
      q_data.diff[2*f]   = rnb - base;
      q_data.diff[2*f+1] = snb - base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_cnt <= '0;
    end else if (q_push) begin
      term_cnt <= done ? '0 : term_cnt + CNT_W'(1);
    end
  end

endmodule

// ----- rtl/rhsd_back.sv -----
// ----------------------------------------------------------------------------
// rhsd_back
// Datapath: one shared 33x33 multiplier folds each term into the six
// derivative accumulators, then runs the chain rule in 24-bit halves and
// saturates the three results into the output register.
// ----------------------------------------------------------------------------
module rhsd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rhsd_pkg::geo_t              geo,
  input  logic                        q_valid,
  input  rhsd_pkg::term_t             q_data,
  output logic                        q_pop,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [rhsd_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int W       = rhsd_pkg::DATA_W;
  localparam int DW      = rhsd_pkg::DIFF_W;
  localparam int ACC_W   = rhsd_pkg::ACC_W;
  localparam int NACC    = rhsd_pkg::NUM_ACC;
  localparam int FRAC    = rhsd_pkg::FRAC_BITS;
  localparam int PROD_W  = 2 * DW;
  localparam int TSUM_W  = PROD_W + 1;
  localparam int SPLIT   = 24;
  localparam int CHAIN_W = 84;
  localparam int IDX_W   = $clog2(NACC);
  localparam int STEP_W  = 4;
  localparam int CHAIN_STEPS = 16;

  localparam logic [IDX_W-1:0] IDX_DU_DR = 3'd0;
  localparam logic [IDX_W-1:0] IDX_DU_DS = 3'd1;
  localparam logic [IDX_W-1:0] IDX_DV_DR = 3'd2;
  localparam logic [IDX_W-1:0] IDX_DV_DS = 3'd3;
  localparam logic [IDX_W-1:0] IDX_DP_DR = 3'd4;
  localparam logic [IDX_W-1:0] IDX_DP_DS = 3'd5;

  localparam logic [1:0] SEL_U = 2'd0;
  localparam logic [1:0] SEL_V = 2'd1;
  localparam logic [1:0] SEL_P = 2'd2;

  localparam logic signed [TSUM_W-1:0] ACC_MAX =
    TSUM_W'($signed({1'b0, {(ACC_W-1){1'b1}}}));
  localparam logic signed [TSUM_W-1:0] ACC_MIN =
    TSUM_W'($signed({1'b1, {(ACC_W-1){1'b0}}}));
  localparam logic signed [CHAIN_W:0] OUT_MAX =
    (CHAIN_W + 1)'($signed({1'b0, {(W-1){1'b1}}}));
  localparam logic signed [CHAIN_W:0] OUT_MIN =
    (CHAIN_W + 1)'($signed({1'b1, {(W-1){1'b0}}}));

  typedef enum logic [2:0] {
    ST_IDLE, ST_TERM, ST_DRAIN, ST_CHAIN, ST_CDRAIN, ST_EMIT
  } state_t;

  typedef struct packed {
    logic             term;   // term update, else chain partial
    logic [IDX_W-1:0] idx;
    logic             hi;     // chain: upper half of accumulator
    logic             last;   // chain: last partial of this output
    logic [1:0]       sel;
  } tag_t;

  state_t                         state;
  logic [STEP_W-1:0]              step;
  logic [NACC-1:0][ACC_W-1:0]     acc;
  logic signed [CHAIN_W-1:0]      chain_acc;

  logic                           p_vld;
  tag_t                           p_tag;
  logic signed [PROD_W-1:0]       p_prod;

  logic                           fin_vld;
  logic [1:0]                     fin_sel;
  logic signed [CHAIN_W-1:0]      fin_sum;

  logic signed [W-1:0]            res_u;
  logic signed [W-1:0]            res_v;
  logic signed [W-1:0]            res_p;

  logic                           issue;
  tag_t                           tag_next;
  logic signed [DW-1:0]           mul_a;
  logic signed [DW-1:0]           mul_b;
  logic signed [PROD_W-1:0]       mul_p;
  logic [IDX_W-1:0]               acc_raddr;
  logic [ACC_W-1:0]               acc_rdata;
  logic signed [W-1:0]            factor;
  logic [IDX_W-1:0]               chain_idx;
  logic signed [TSUM_W-1:0]       t_sum;
  logic [ACC_W-1:0]               t_sat;
  logic signed [CHAIN_W-1:0]      c_add;
  logic signed [CHAIN_W-1:0]      c_sum;
  logic signed [CHAIN_W-1:0]      fin_q;
  logic signed [CHAIN_W:0]        fin_neg;
  logic signed [W-1:0]            fin_sat;
  logic                           out_load;

  // Chain schedule: each step pair is one factor times one accumulator,
  // upper half first.
  always_comb begin
    unique case (step[STEP_W-1:1])
      3'd0: begin factor = geo.r_x; chain_idx = IDX_DP_DR; end
      3'd1: begin factor = geo.s_x; chain_idx = IDX_DP_DS; end
      3'd2: begin factor = geo.r_y; chain_idx = IDX_DP_DR; end
      3'd3: begin factor = geo.s_y; chain_idx = IDX_DP_DS; end
      3'd4: begin factor = geo.r_x; chain_idx = IDX_DU_DR; end
      3'd5: begin factor = geo.s_x; chain_idx = IDX_DU_DS; end
      3'd6: begin factor = geo.r_y; chain_idx = IDX_DV_DR; end
      3'd7: begin factor = geo.s_y; chain_idx = IDX_DV_DS; end
      default: begin factor = geo.r_x; chain_idx = IDX_DU_DR; end
    endcase
  end

  assign acc_raddr = (state == ST_CHAIN) ? chain_idx : p_tag.idx;
  assign acc_rdata = acc[acc_raddr];

  always_comb begin
    issue    = 1'b0;
    tag_next = '0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_TERM: begin
        issue         = 1'b1;
        tag_next.term = 1'b1;
        tag_next.idx  = step[IDX_W-1:0];
        mul_a         = DW'(q_data.weight);
        mul_b         = $signed(q_data.diff[step[IDX_W-1:0]]);
      end
      ST_CHAIN: begin
        issue         = 1'b1;
        tag_next.hi   = !step[0];
        tag_next.last = (step == STEP_W'(3)) || (step == STEP_W'(7)) ||
                        (step == STEP_W'(CHAIN_STEPS - 1));
        tag_next.sel  = (step < STEP_W'(4)) ? SEL_U :
                        (step < STEP_W'(8)) ? SEL_V : SEL_P;
        mul_a         = DW'(factor);
        mul_b         = step[0] ? DW'({1'b0, acc_rdata[SPLIT-1:0]})
                                : DW'($signed(acc_rdata[ACC_W-1:SPLIT]));
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Term update: floor(w * diff / 2^(FRAC+1)), saturating add.
  assign t_sum = TSUM_W'($signed(acc_rdata)) + TSUM_W'(p_prod >>> (FRAC + 1));
  always_comb begin
    if (t_sum > ACC_MAX)      t_sat = ACC_MAX[ACC_W-1:0];
    else if (t_sum < ACC_MIN) t_sat = ACC_MIN[ACC_W-1:0];
    else                      t_sat = t_sum[ACC_W-1:0];
  end

  assign c_add = p_tag.hi ? (CHAIN_W'(p_prod) <<< SPLIT) : CHAIN_W'(p_prod);
  assign c_sum = chain_acc + c_add;

  // Result: -floor(sum / 2^FRAC), saturated to 32 bits.
  assign fin_q   = fin_sum >>> FRAC;
  assign fin_neg = -((CHAIN_W + 1)'(fin_q));
  always_comb begin
    if (fin_neg > OUT_MAX)      fin_sat = OUT_MAX[W-1:0];
    else if (fin_neg < OUT_MIN) fin_sat = OUT_MIN[W-1:0];
    else                        fin_sat = fin_neg[W-1:0];
  end

  assign q_pop    = (state == ST_TERM) && (step == STEP_W'(NACC - 1));
  assign out_load = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      acc           <= '0;
      chain_acc     <= '0;
      p_vld         <= 1'b0;
      fin_vld       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      p_vld   <= issue;
      fin_vld <= 1'b0;

      if (p_vld && p_tag.term) begin
        acc[p_tag.idx] <= t_sat;
      end
      if (p_vld && !p_tag.term) begin
        if (p_tag.last) begin
          fin_vld   <= 1'b1;
          chain_acc <= '0;
        end else begin
          chain_acc <= c_sum;
        end
      end

      if (m_axis_tready && !out_load) m_axis_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_TERM;
            step  <= '0;
          end
        end
        ST_TERM: begin
          if (step == STEP_W'(NACC - 1)) begin
            step  <= '0;
            state <= q_data.done ? ST_DRAIN : ST_IDLE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_CHAIN;
          step  <= '0;
        end
        ST_CHAIN: begin
          if (step == STEP_W'(CHAIN_STEPS - 1)) begin
            state <= ST_CDRAIN;
            step  <= '0;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_CDRAIN: begin
          if (step == STEP_W'(1)) begin
            state <= ST_EMIT;
            step  <= '0;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res_p, res_v, res_u};
            acc           <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_tag  <= tag_next;
    p_prod <= mul_p;
    if (p_vld && !p_tag.term && p_tag.last) begin
      fin_sum <= c_sum;
      fin_sel <= p_tag.sel;
    end
    if (fin_vld) begin
      unique case (fin_sel)
        SEL_U:   res_u <= fin_sat;
        SEL_V:   res_v <= fin_sat;
        default: res_p <= fin_sat;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_term_in_chain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHAIN) |-> !(p_vld && p_tag.term))
    else $error("term update still in flight during chain rule");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (acc == '0) && m_axis_tvalid)
    else $error("accumulators not cleared on result load");

  a_fin_in_chain: assert property (@(posedge clk) disable iff (rst)
    fin_vld |-> (state == ST_CHAIN) || (state == ST_CDRAIN))
    else $error("result conversion outside chain rule");
`endif

endmodule
